// ----- sv/ectt_pkg.sv -----
// Shared types, widths and constants for the external clock tempo tracker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ectt_pkg;

    localparam int TIME_BITS    = 40;   // timestamp width
    localparam int HIST_DEPTH   = 3;    // period history entries
    localparam int PER_W        = 27;   // periods, median, gap, unity
    localparam int RATE_W       = 24;   // Q8.16 rate
    localparam int RATE_FRAC    = 16;   // fraction bits of the rate
    localparam int POT_W        = 16;   // knob, Q0.16
    localparam int MS_W         = 32;   // millisecond clock
    localparam int TP_W         = 5;    // timeout_periods
    localparam int CLAMP_W      = 17;   // timeout clamps in ms
    localparam int REFR_W       = 20;   // refractory_us
    localparam int MED_MS_W     = 18;   // (2^27 - 1) / 1000 fits 18 bits
    localparam int LIMIT_W      = MED_MS_W + TP_W;

    // shared divider: wide enough for unity << 16 and for a timestamp
    localparam int DIV_W     = (TIME_BITS > PER_W + RATE_FRAC) ? TIME_BITS
                                                               : PER_W + RATE_FRAC;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [PER_W-1:0] US_PER_MS = PER_W'(1000);

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = ((TIME_BITS + POT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((4 + PER_W + RATE_W + 7) / 8) * 8;

    // register port
    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int PADDR_W  = REG_IDX_W + 2;
    localparam int PDATA_W  = 32;

    localparam logic [REG_IDX_W-1:0] REG_REFRACTORY = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_GAP        = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_TPERIODS   = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_TMIN       = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_TMAX       = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_EPS        = REG_IDX_W'(5);
    localparam logic [REG_IDX_W-1:0] REG_UNITY      = REG_IDX_W'(6);
    localparam logic [REG_IDX_W-1:0] REG_RATE_MAX   = REG_IDX_W'(7);

    localparam logic [REFR_W-1:0]  RST_REFRACTORY = REFR_W'(200);
    localparam logic [PER_W-1:0]   RST_GAP        = PER_W'(10000000);
    localparam logic [TP_W-1:0]    RST_TPERIODS   = TP_W'(2);
    localparam logic [CLAMP_W-1:0] RST_TMIN       = CLAMP_W'(90);
    localparam logic [CLAMP_W-1:0] RST_TMAX       = CLAMP_W'(10000);
    localparam logic [POT_W-1:0]   RST_EPS        = POT_W'(1311);
    localparam logic [PER_W-1:0]   RST_UNITY      = PER_W'(500000);
    localparam logic [RATE_W-1:0]  RST_RATE_MAX   = RATE_W'(4194304);

    typedef struct packed {
        logic [REFR_W-1:0]  refractory;
        logic [PER_W-1:0]   gap;
        logic [TP_W-1:0]    tperiods;
        logic [CLAMP_W-1:0] tmin;
        logic [CLAMP_W-1:0] tmax;
        logic [POT_W-1:0]   eps;
        logic [PER_W-1:0]   unity;
        logic [RATE_W-1:0]  rate_max;
    } cfg_t;

endpackage

`default_nettype wire

// ----- sv/ext_clock_tempo_tracker.sv -----
// External clock tempo tracker: sequencer, tracking state and result register.
// Depends on ectt_pkg, ectt_cfg (register port) and ectt_div (serial divider).
`default_nettype none

// Usage
//   Input stream s_*: one transfer per item. s_tuser is the action (0 clock
//   edge, 1 control poll); s_tdata carries the timestamp and the knob.
//   Result stream m_*: exactly one transfer per input item, in order.
//   Registers are to be written over the APB-style port while the block is
//   idle; the block itself does not enforce this.
// Steps per item (one item in flight at a time)
//   chatter or gap edge:   no divider pass
//   accepted edge:         two passes of the divider (rate, then median in ms)
//   poll:                  one divider pass
//   The shared divider, one quotient bit per cycle, paces these steps.
// Reset (aresetn low, synchronous): registers return to their defaults and
//   the tracking state is cleared but for the timeout limit; no result is pending.
// Stall: a finished result waits in the output register; the next item is
//   still taken and worked on, and its result waits until m_tready frees
//   the output register.
module ext_clock_tempo_tracker (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata fields, low bit up: time_us[TIME_BITS], rate_pot[16]
    input  logic [ectt_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser fields: action (0 edge, 1 poll)
    input  logic                            s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata fields, low bit up: clock_active, clock_held,
    // median_period_us[27], tempo_rate_q16[24], edge_accepted, timed_out
    output logic [ectt_pkg::M_TDATA_W-1:0]  m_tdata,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ectt_pkg::PADDR_W-1:0]    paddr,
    input  logic [ectt_pkg::PDATA_W-1:0]    pwdata,
    output logic [ectt_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import ectt_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_EDGE      = 4'd1;
    localparam logic [3:0] ST_MED       = 4'd2;
    localparam logic [3:0] ST_RATE_WAIT = 4'd3;
    localparam logic [3:0] ST_MS_WAIT   = 4'd4;
    localparam logic [3:0] ST_POLL      = 4'd5;
    localparam logic [3:0] ST_POLL_WAIT = 4'd6;
    localparam logic [3:0] ST_DONE      = 4'd7;

    cfg_t cfg;

    ectt_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [PER_W-1:0]  div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  div_quot;

    ectt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // captured item
    logic [3:0]            state_reg, state_next;
    logic                  act_reg, act_next;
    logic [TIME_BITS-1:0]  time_reg, time_next;
    logic [POT_W-1:0]      pot_reg, pot_next;

    // tracking state
    logic [TIME_BITS-1:0]  last_reg, last_next;
    logic [TIME_BITS-1:0]  seen_reg, seen_next;
    logic [MS_W-1:0]       esm_reg, esm_next;
    logic [PER_W-1:0]      hist_reg [HIST_DEPTH];
    logic [PER_W-1:0]      hist_next [HIST_DEPTH];
    logic [PER_W-1:0]      median_reg, median_next;
    logic [MED_MS_W-1:0]   med_ms_reg, med_ms_next;
    logic [RATE_W-1:0]     rate_reg, rate_next;
    logic                  active_reg, active_next;
    logic                  held_reg, held_next;
    logic [POT_W-1:0]      knob_reg, knob_next;
    logic [LIMIT_W-1:0]    limit_reg, limit_next;
    logic                  edge_acc_reg, edge_acc_next;
    logic                  timed_reg, timed_next;

    // result register
    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;

    // datapath
    logic [TIME_BITS-1:0]  period;
    logic                  is_chatter, is_gap;
    logic [PER_W-1:0]      per;
    logic [PER_W-1:0]      mid;
    logic [POT_W-1:0]      pot_diff;
    logic [LIMIT_W-1:0]    lim_prod, lim_lo, lim_cl;
    logic [MS_W-1:0]       now_ms, esm_new, elapsed;

    function automatic logic [PER_W-1:0] mid3(input logic [PER_W-1:0] a,
                                              input logic [PER_W-1:0] b,
                                              input logic [PER_W-1:0] c);
        logic [PER_W-1:0] lo, hi, m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    assign period     = time_reg - last_reg;   // wraps modulo 2^TIME_BITS
    assign is_chatter = period < TIME_BITS'(cfg.refractory);
    assign is_gap     = period >= TIME_BITS'(cfg.gap);
    assign per        = period[PER_W-1:0];     // below gap, so fits
    assign mid        = mid3(hist_reg[0], hist_reg[1], hist_reg[2]);
    assign pot_diff   = (pot_reg > knob_reg) ? pot_reg - knob_reg : knob_reg - pot_reg;

    // adaptive timeout in ms; the max clamp wins over the min
    assign lim_prod = LIMIT_W'(med_ms_reg) * LIMIT_W'(cfg.tperiods);
    assign lim_lo   = (lim_prod < LIMIT_W'(cfg.tmin)) ? LIMIT_W'(cfg.tmin) : lim_prod;
    assign lim_cl   = (lim_lo > LIMIT_W'(cfg.tmax)) ? LIMIT_W'(cfg.tmax) : lim_lo;

    assign now_ms  = div_quot[MS_W-1:0];
    assign esm_new = (last_reg != seen_reg) ? now_ms : esm_reg;
    assign elapsed = now_ms - esm_new;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        time_next     = time_reg;
        pot_next      = pot_reg;
        last_next     = last_reg;
        seen_next     = seen_reg;
        esm_next      = esm_reg;
        for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_next[i] = hist_reg[i];
        end
        median_next   = median_reg;
        med_ms_next   = med_ms_reg;
        rate_next     = rate_reg;
        active_next   = active_reg;
        held_next     = held_reg;
        knob_next     = knob_reg;
        limit_next    = limit_reg;
        edge_acc_next = edge_acc_reg;
        timed_next    = timed_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        div_start     = 1'b0;
        div_dividend  = DIV_W'({cfg.unity, {RATE_FRAC{1'b0}}});
        div_divisor   = mid;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next      = s_tuser;
                    time_next     = s_tdata[TIME_BITS-1:0];
                    pot_next      = s_tdata[TIME_BITS +: POT_W];
                    edge_acc_next = 1'b0;
                    timed_next    = 1'b0;
                    state_next    = s_tuser ? ST_POLL : ST_EDGE;
                end
            end
            ST_EDGE: begin
                last_next = time_reg;
                if (is_chatter) begin
                    state_next = ST_DONE;
                end else if (is_gap) begin
                    active_next = 1'b0;      // re-anchor, hold untouched
                    state_next  = ST_DONE;
                end else begin
                    if (!active_reg) begin
                        for (int i = 0; i < HIST_DEPTH; i++) begin
                            hist_next[i] = per;
                        end
                    end else begin
                        for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                            hist_next[i] = hist_reg[i+1];
                        end
                        hist_next[HIST_DEPTH-1] = per;
                    end
                    active_next = 1'b1;
                    state_next  = ST_MED;
                end
            end
            ST_MED: begin
                median_next = mid;
                if (mid == '0) begin
                    // only reachable with zero refractory time
                    rate_next     = cfg.rate_max;
                    med_ms_next   = '0;
                    edge_acc_next = 1'b1;
                    state_next    = ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_RATE_WAIT;
                end
            end
            ST_RATE_WAIT: begin
                div_dividend = DIV_W'(median_reg);
                div_divisor  = US_PER_MS;
                if (div_done) begin
                    rate_next  = (div_quot > DIV_W'(cfg.rate_max)) ? cfg.rate_max
                                                                 : div_quot[RATE_W-1:0];
                    div_start  = 1'b1;
                    state_next = ST_MS_WAIT;
                end
            end
            ST_MS_WAIT: begin
                if (div_done) begin
                    med_ms_next   = div_quot[MED_MS_W-1:0];
                    edge_acc_next = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_POLL: begin
                if (active_reg) begin
                    held_next = 1'b0;
                end else if (held_reg && (pot_diff > cfg.eps)) begin
                    held_next = 1'b0;
                end
                limit_next   = lim_cl;
                div_dividend = DIV_W'(time_reg);
                div_divisor  = US_PER_MS;
                div_start    = 1'b1;
                state_next   = ST_POLL_WAIT;
            end
            ST_POLL_WAIT: begin
                if (div_done) begin
                    seen_next = last_reg;
                    esm_next  = esm_new;
                    if (active_reg && (elapsed > MS_W'(limit_reg))) begin
                        active_next = 1'b0;
                        held_next   = 1'b1;
                        knob_next   = pot_reg;
                        timed_next  = 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({timed_reg, edge_acc_reg, rate_reg,
                                               median_reg, held_reg, active_reg});
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            last_reg     <= '0;
            seen_reg     <= '0;
            esm_reg      <= '0;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
            median_reg   <= '0;
            med_ms_reg   <= '0;
            rate_reg     <= '0;
            active_reg   <= 1'b0;
            held_reg     <= 1'b0;
            knob_reg     <= '0;
            edge_acc_reg <= 1'b0;
            timed_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            last_reg     <= last_next;
            seen_reg     <= seen_next;
            esm_reg      <= esm_next;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_reg[i] <= hist_next[i];
            end
            median_reg   <= median_next;
            med_ms_reg   <= med_ms_next;
            rate_reg     <= rate_next;
            active_reg   <= active_next;
            held_reg     <= held_next;
            knob_reg     <= knob_next;
            edge_acc_reg <= edge_acc_next;
            timed_reg    <= timed_next;
        end
        act_reg    <= act_next;
        time_reg   <= time_next;
        pot_reg    <= pot_next;
        limit_reg  <= limit_next;
        m_data_reg <= m_data_next;
    end

    // an item is an edge or a poll, never both outcomes
    a_excl_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        !(edge_acc_reg && timed_reg))
        else $error("edge_accepted and timed_out both set");

    a_timeout_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        timed_reg |-> (held_reg && !active_reg))
        else $error("timeout without hold");

    a_accept_active: assert property (@(posedge aclk) disable iff (!aresetn)
        edge_acc_reg |-> active_reg)
        else $error("accepted edge left tracker inactive");

    a_div_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_RATE_WAIT || state_reg == ST_MS_WAIT ||
                      state_reg == ST_POLL_WAIT))
        else $error("divider finished outside a wait state");

    a_poll_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == (act_reg ? ST_POLL : ST_EDGE)))
        else $error("accepted item not dispatched");

endmodule

`default_nettype wire

// ----- sv/ectt_cfg.sv -----
// Register file of the tempo tracker behind an APB-style port.
// Depends on ectt_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module ectt_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ectt_pkg::PADDR_W-1:0]  paddr,
    input  logic [ectt_pkg::PDATA_W-1:0]  pwdata,
    output logic [ectt_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output ectt_pkg::cfg_t                cfg
);
    import ectt_pkg::*;

    cfg_t                 cfg_reg, cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_REFRACTORY: cfg_next.refractory = pwdata[REFR_W-1:0];
                REG_GAP:        cfg_next.gap        = pwdata[PER_W-1:0];
                REG_TPERIODS:   cfg_next.tperiods   = pwdata[TP_W-1:0];
                REG_TMIN:       cfg_next.tmin       = pwdata[CLAMP_W-1:0];
                REG_TMAX:       cfg_next.tmax       = pwdata[CLAMP_W-1:0];
                REG_EPS:        cfg_next.eps        = pwdata[POT_W-1:0];
                REG_UNITY:      cfg_next.unity      = pwdata[PER_W-1:0];
                REG_RATE_MAX:   cfg_next.rate_max   = pwdata[RATE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_REFRACTORY: prdata = PDATA_W'(cfg_reg.refractory);
            REG_GAP:        prdata = PDATA_W'(cfg_reg.gap);
            REG_TPERIODS:   prdata = PDATA_W'(cfg_reg.tperiods);
            REG_TMIN:       prdata = PDATA_W'(cfg_reg.tmin);
            REG_TMAX:       prdata = PDATA_W'(cfg_reg.tmax);
            REG_EPS:        prdata = PDATA_W'(cfg_reg.eps);
            REG_UNITY:      prdata = PDATA_W'(cfg_reg.unity);
            REG_RATE_MAX:   prdata = PDATA_W'(cfg_reg.rate_max);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.refractory <= RST_REFRACTORY;
            cfg_reg.gap        <= RST_GAP;
            cfg_reg.tperiods   <= RST_TPERIODS;
            cfg_reg.tmin       <= RST_TMIN;
            cfg_reg.tmax       <= RST_TMAX;
            cfg_reg.eps        <= RST_EPS;
            cfg_reg.unity      <= RST_UNITY;
            cfg_reg.rate_max   <= RST_RATE_MAX;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/ectt_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ectt_pkg for DIV_W, DIV_CNT_W and PER_W.
`default_nettype none

module ectt_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ectt_pkg::DIV_W-1:0]  dividend,
    input  logic [ectt_pkg::PER_W-1:0]  divisor,
    output logic                        done,
    output logic [ectt_pkg::DIV_W-1:0]  quotient
);
    import ectt_pkg::*;

    // dividend bits shift out at the top while quotient bits shift in below
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [PER_W-1:0]     rem_reg, rem_next;
    logic [PER_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [PER_W:0]       rem_shift;
    logic                 fits;

    assign rem_shift = {rem_reg, dvd_reg[DIV_W-1]};
    assign fits      = rem_shift >= {1'b0, dsr_reg};
    assign done      = done_reg;
    assign quotient  = dvd_reg;

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIV_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? PER_W'(rem_shift - {1'b0, dsr_reg}) : rem_shift[PER_W-1:0];
            dvd_next = {dvd_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

`default_nettype wire

// ----- test/tb_ext_clock_tempo_tracker.sv -----
// Self-checking testbench for ext_clock_tempo_tracker: edge/poll stream in, one result out.
// Predicts every result with its own tracker copy; needs only ectt_pkg and the block's RTL.
module tb_ext_clock_tempo_tracker;
    import ectt_pkg::*;

    // item kinds carried on s_tuser
    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_POLL = 1'b1;

    // m_tdata layout, low bit up
    localparam int ACTIVE_BIT = 0;
    localparam int HELD_BIT   = 1;
    localparam int MED_LSB    = 2;
    localparam int RATE_LSB   = MED_LSB + PER_W;
    localparam int ACC_BIT    = RATE_LSB + RATE_W;
    localparam int TMO_BIT    = ACC_BIT + 1;

    localparam int IDLE_LIMIT   = 4000;  // cycles with no transfer anywhere
    localparam int ITEMS_PER_PH = 95;    // random items per register setting
    localparam int MAX_REPORTS  = 20;

    // writable bits of each register
    localparam logic [31:0] REG_MASK [NUM_REGS] = '{
        32'((64'd1 << REFR_W) - 1),  32'((64'd1 << PER_W) - 1),
        32'((64'd1 << TP_W) - 1),    32'((64'd1 << CLAMP_W) - 1),
        32'((64'd1 << CLAMP_W) - 1), 32'((64'd1 << POT_W) - 1),
        32'((64'd1 << PER_W) - 1),   32'((64'd1 << RATE_W) - 1)
    };

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_TRICKLE} rx_mode_t;

    typedef struct packed {
        logic              active;
        logic              held;
        logic [PER_W-1:0]  median;
        logic [RATE_W-1:0] rate;
        logic              accepted;
        logic              timed;
    } tempo_result_t;

    // ---------------------------------------------------------------- DUT signals
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [PDATA_W-1:0]   pwdata    = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    ext_clock_tempo_tracker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- tracker copy
    // Register shadow, kept masked to each register's width.
    logic [31:0] reg_shadow [NUM_REGS];

    logic [TIME_BITS-1:0] trk_last_edge = '0;
    logic [TIME_BITS-1:0] trk_seen_edge = '0;
    logic [MS_W-1:0]      trk_seen_ms   = '0;
    logic [PER_W-1:0]     trk_hist [HIST_DEPTH] = '{default: '0};
    logic [PER_W-1:0]     trk_median    = '0;
    logic [RATE_W-1:0]    trk_rate      = '0;
    logic                 trk_active    = 1'b0;
    logic                 trk_held      = 1'b0;
    logic [POT_W-1:0]     trk_knob      = '0;

    tempo_result_t tempo_expected [$];

    int error_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int edges_accepted  = 0;
    int timeouts_seen   = 0;
    int knob_exits      = 0;
    int reg_settings    = 0;

    // Stimulus state shared by the test tasks.
    logic [TIME_BITS-1:0] stim_time = '0;
    int unsigned burst_left = 0;
    bit steady_sender = 1'b0;

    // Advance the tracker copy by one item and return the result it gives.
    function automatic tempo_result_t predict_tempo(input logic act,
                                                    input logic [TIME_BITS-1:0] now,
                                                    input logic [POT_W-1:0] pot);
        tempo_result_t res;
        logic [TIME_BITS-1:0] period;
        logic [PER_W-1:0] per, a, b, c;
        logic [63:0] quo, limit;
        logic [MS_W-1:0] now_ms, elapsed;
        logic [POT_W-1:0] knob_dist;
        res = '0;
        if (act == ACT_EDGE) begin
            period = now - trk_last_edge;   // wraps modulo 2^TIME_BITS
            trk_last_edge = now;
            if (64'(period) < 64'(reg_shadow[REG_REFRACTORY])) begin
                // chatter: only the edge time moves
            end else if (64'(period) >= 64'(reg_shadow[REG_GAP])) begin
                trk_active = 1'b0;          // re-anchor, hold untouched
            end else begin
                per = period[PER_W-1:0];
                if (!trk_active) begin
                    trk_hist[0] = per;
                    trk_hist[1] = per;
                    trk_hist[2] = per;
                    trk_active  = 1'b1;
                end else begin
                    trk_hist[0] = trk_hist[1];
                    trk_hist[1] = trk_hist[2];
                    trk_hist[2] = per;
                end
                a = trk_hist[0];
                b = trk_hist[1];
                c = trk_hist[2];
                trk_median = (a > b) ? ((b > c) ? b : ((a > c) ? c : a))
                                     : ((a > c) ? a : ((b > c) ? c : b));
                if (trk_median == '0) begin
                    quo = 64'(reg_shadow[REG_RATE_MAX]);
                end else begin
                    quo = (64'(reg_shadow[REG_UNITY]) << RATE_FRAC) / 64'(trk_median);
                    if (quo > 64'(reg_shadow[REG_RATE_MAX]))
                        quo = 64'(reg_shadow[REG_RATE_MAX]);
                end
                trk_rate = quo[RATE_W-1:0];
                res.accepted = 1'b1;
                edges_accepted++;
            end
        end else begin
            now_ms = MS_W'(now / 1000);
            if (trk_active) begin
                trk_held = 1'b0;
            end else if (trk_held) begin
                knob_dist = (pot > trk_knob) ? pot - trk_knob : trk_knob - pot;
                if (32'(knob_dist) > reg_shadow[REG_EPS]) begin
                    trk_held = 1'b0;
                    knob_exits++;
                end
            end
            if (trk_last_edge != trk_seen_edge) begin
                trk_seen_edge = trk_last_edge;
                trk_seen_ms   = now_ms;
            end
            limit = 64'(trk_median / 1000) * 64'(reg_shadow[REG_TPERIODS]);
            if (limit < 64'(reg_shadow[REG_TMIN]))
                limit = 64'(reg_shadow[REG_TMIN]);
            if (limit > 64'(reg_shadow[REG_TMAX]))    // max wins over min
                limit = 64'(reg_shadow[REG_TMAX]);
            elapsed = now_ms - trk_seen_ms;
            if (trk_active && 64'(elapsed) > limit) begin
                trk_active = 1'b0;
                trk_held   = 1'b1;
                trk_knob   = pot;
                res.timed  = 1'b1;
                timeouts_seen++;
            end
        end
        res.active = trk_active;
        res.held   = trk_held;
        res.median = trk_median;
        res.rate   = trk_rate;
        return res;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s: expected 0x%0h, got 0x%0h", $time, what, want, seen);
        end
    endtask

    // ---------------------------------------------------------------- result checker
    always @(posedge aclk) begin : result_check
        tempo_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (tempo_expected.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result transfer with nothing expected, got 0x%0h",
                             $time, m_tdata);
            end else begin
                want = tempo_expected.pop_front();
                check_field($sformatf("result %0d clock_active", results_checked),
                            32'(want.active), 32'(m_tdata[ACTIVE_BIT]));
                check_field($sformatf("result %0d clock_held", results_checked),
                            32'(want.held), 32'(m_tdata[HELD_BIT]));
                check_field($sformatf("result %0d median_period_us", results_checked),
                            32'(want.median), 32'(m_tdata[MED_LSB +: PER_W]));
                check_field($sformatf("result %0d tempo_rate_q16", results_checked),
                            32'(want.rate), 32'(m_tdata[RATE_LSB +: RATE_W]));
                check_field($sformatf("result %0d edge_accepted", results_checked),
                            32'(want.accepted), 32'(m_tdata[ACC_BIT]));
                check_field($sformatf("result %0d timed_out", results_checked),
                            32'(want.timed), 32'(m_tdata[TMO_BIT]));
                results_checked++;
            end
        end
    end

    // ---------------------------------------------------------------- receiver stalls
    // The stall pattern is redrawn from a tick counter: open, random, periodic,
    // or a trickle in which m_tready is seldom high.
    rx_mode_t rx_mode = RX_OPEN;
    int unsigned rx_tick = 0;

    always @(negedge aclk) begin
        rx_tick++;
        if (rx_tick % 256 == 0)
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_tready <= ((rx_tick % 7) < 3);
            default:     m_tready <= ((rx_tick % 16) == 0);
        endcase
    end

    // ---------------------------------------------------------------- watchdog
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, tempo_expected.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- drivers
    // One item transfer. Bursts of random length, random gaps in between;
    // steady_sender turns the gaps off. Prediction happens at acceptance.
    task automatic send_item(input logic act, input logic [TIME_BITS-1:0] now,
                             input logic [POT_W-1:0] pot);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (!steady_sender && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 8);
        end
        @(negedge aclk);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= S_TDATA_W'({pot, now});
        do @(posedge aclk); while (!s_tready);
        tempo_expected.push_back(predict_tempo(act, now, pot));
        items_sent++;
        burst_left--;
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain_results;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tempo_expected.size() != 0)
            @(posedge aclk);
    endtask

    task automatic reg_read_check(input logic [REG_IDX_W-1:0] idx);
        logic [31:0] got;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field($sformatf("register %0d readback", idx), reg_shadow[idx], got);
    endtask

    // Write a register (block idle), then read it back.
    task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        reg_shadow[idx] = value & REG_MASK[idx];
        reg_settings++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_read_check(idx);
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_register_defaults;
        for (int i = 0; i < NUM_REGS; i++)
            reg_read_check(REG_IDX_W'(i));
    endtask

    // Reset settings: chatter, gap, seed, median, timeout, hold and its exit,
    // time going backwards, wrap of the timestamp, extreme time and knob.
    task automatic test_directed_tracking;
        logic [TIME_BITS-1:0] t;
        send_item(ACT_POLL, 40'd0, 16'h0000);
        send_item(ACT_EDGE, 40'd100, 16'h0000);          // under refractory
        t = 40'd20_000_100;
        send_item(ACT_EDGE, t, 16'h0000);                // gap, re-anchor
        t += 500_000;
        send_item(ACT_EDGE, t, 16'h0000);                // seeds history
        send_item(ACT_EDGE, t + 150, 16'h0000);          // chatter moves last edge
        t += 150 + 500_000;
        send_item(ACT_EDGE, t, 16'h0000);
        send_item(ACT_POLL, t + 1000, 16'h4000);
        t += 250_000;
        send_item(ACT_EDGE, t, 16'h0000);
        send_item(ACT_POLL, t + 1000, 16'h4000);
        t += 1_000_000;
        send_item(ACT_EDGE, t, 16'h0000);
        send_item(ACT_POLL, t + 1000, 16'h4000);         // edge seen here
        send_item(ACT_POLL, t + 501_000, 16'h4000);      // inside the timeout
        send_item(ACT_POLL, t + 2_001_000, 16'h4000);    // times out, knob latched
        send_item(ACT_POLL, t + 2_002_000, 16'h4000 + 16'd1311);  // inside deadband
        send_item(ACT_POLL, t + 2_003_000, 16'h4000 + 16'd1312);  // leaves hold
        send_item(ACT_POLL, t + 2_004_000, 16'hFFFF);
        send_item(ACT_EDGE, t - 5_000_000, 16'h0000);    // time goes backwards
        send_item(ACT_EDGE, 40'hFF_FFFF_FF00, 16'hFFFF);
        send_item(ACT_EDGE, 40'd599_744, 16'h0000);      // wrapped, 600 ms period
        send_item(ACT_EDGE, 40'd1_199_744, 16'h0000);
        send_item(ACT_POLL, 40'hFF_FFFF_FFFF, 16'hFFFF);
        send_item(ACT_POLL, 40'hFF_FFFF_FFFF, 16'h0000);
        drain_results();
    endtask

    // Registers at their extremes: zero refractory and a zero median, minimum
    // clamp above the maximum, zero deadband; then the opposite corner with a
    // zero gap register, the widest deadband and a zero rate limit.
    task automatic test_register_extremes;
        logic [TIME_BITS-1:0] t;
        set_reg(REG_REFRACTORY, 32'd0);
        set_reg(REG_GAP,        REG_MASK[REG_GAP]);
        set_reg(REG_UNITY,      32'd1);
        set_reg(REG_RATE_MAX,   REG_MASK[REG_RATE_MAX]);
        set_reg(REG_TPERIODS,   32'd16);
        set_reg(REG_TMIN,       32'd100_000);
        set_reg(REG_TMAX,       32'd0);
        set_reg(REG_EPS,        32'd0);
        t = 40'h12_3456_7890;
        send_item(ACT_EDGE, t, 16'h1234);
        send_item(ACT_EDGE, t, 16'h1234);                // zero period accepted
        send_item(ACT_EDGE, t + 3, 16'h1234);
        send_item(ACT_EDGE, t + 6, 16'h1234);
        send_item(ACT_POLL, t + 1000, 16'h1234);
        send_item(ACT_POLL, t + 3000, 16'h1234);         // limit clamped to zero
        send_item(ACT_POLL, t + 4000, 16'h1234);
        send_item(ACT_POLL, t + 5000, 16'h1235);
        drain_results();

        set_reg(REG_REFRACTORY, REG_MASK[REG_REFRACTORY]);
        set_reg(REG_GAP,        32'd0);
        set_reg(REG_UNITY,      REG_MASK[REG_UNITY]);
        set_reg(REG_RATE_MAX,   32'd0);
        set_reg(REG_TPERIODS,   32'd1);
        set_reg(REG_TMIN,       32'd0);
        set_reg(REG_TMAX,       REG_MASK[REG_TMAX]);
        set_reg(REG_EPS,        REG_MASK[REG_EPS]);
        t += 10_000_000;
        send_item(ACT_EDGE, t, 16'h0000);                // every edge past refractory re-anchors
        send_item(ACT_EDGE, t + 10, 16'h0000);
        t += 10 + 2_000_000;
        send_item(ACT_EDGE, t, 16'h0000);
        send_item(ACT_POLL, t + 1000, 16'h0000);
        drain_results();

        set_reg(REG_GAP, REG_MASK[REG_GAP]);
        t += 1_048_575;
        send_item(ACT_EDGE, t, 16'h0000);                // just at refractory
        send_item(ACT_POLL, t + 1000, 16'h0000);
        send_item(ACT_POLL, t + 2_001_000, 16'h0000);    // times out
        send_item(ACT_POLL, t + 2_002_000, 16'hFFFF);    // cannot leave the deadband
        t += 3_000_000;
        send_item(ACT_EDGE, t, 16'hFFFF);
        send_item(ACT_POLL, t + 1000, 16'hFFFF);         // live clock ends hold
        drain_results();
    endtask

    // A clock run with jitter, chatter and polls, then optionally a stop, mostly with
    // a timeout, and knob moves around the latched position.
    task automatic run_clock_segment(input bit wild);
        logic [TIME_BITS-1:0] edge_at;
        int unsigned lo, hi, small_hi, base, jit, per, tmax, eps, n_edges;
        logic [POT_W-1:0] knob;
        int kv, knob_move;
        lo = reg_shadow[REG_REFRACTORY] + 1;
        if (wild) begin
            hi = lo + 3_000_000;
        end else begin
            hi = (reg_shadow[REG_GAP] > lo + 1) ? reg_shadow[REG_GAP] - 1 : lo;
            if (hi > 2_000_000)
                hi = 2_000_000;
            if (hi < lo)
                hi = lo;
        end
        small_hi = (hi - lo > 3000) ? lo + 3000 : hi;
        base = ($urandom_range(0, 3) == 0) ? $urandom_range(lo, small_hi)
                                           : $urandom_range(lo, hi);
        jit = base / 8;
        knob = POT_W'($urandom);
        n_edges = $urandom_range(2, 10);
        edge_at = stim_time;
        for (int e = 0; e < n_edges; e++) begin
            if ($urandom_range(0, 7) == 0)      // contact bounce after the last edge
                send_item(ACT_EDGE, edge_at + $urandom_range(0, lo - 1), knob);
            per = base - jit + $urandom_range(0, 2 * jit);
            edge_at += per;
            stim_time = edge_at;
            send_item(ACT_EDGE, edge_at, knob);
            repeat ($urandom_range(0, 2)) begin
                stim_time += $urandom_range(1, per / 4 + 1);
                knob += POT_W'($urandom_range(0, 64)) - POT_W'(32);
                send_item(ACT_POLL, stim_time, knob);
            end
        end
        if ($urandom_range(0, 2) == 0)
            return;                             // tempo change, next run follows
        tmax = reg_shadow[REG_TMAX];
        eps  = reg_shadow[REG_EPS];
        stim_time += 1000;
        send_item(ACT_POLL, stim_time, knob);
        repeat ($urandom_range(0, 2)) begin
            stim_time += $urandom_range(1000, tmax * 500 + 1000);
            send_item(ACT_POLL, stim_time, knob);
        end
        if ($urandom_range(0, 3) != 0) begin
            // past the largest possible limit
            stim_time += 40'(tmax + 1) * 1000 + $urandom_range(0, 999_999);
            send_item(ACT_POLL, stim_time, knob);
        end
        repeat ($urandom_range(1, 3)) begin
            knob_move = int'($urandom_range(0, 2 * eps + 2));
            kv = ($urandom_range(0, 1) != 0) ? int'(knob) + knob_move
                                             : int'(knob) - knob_move;
            if (kv < 0)
                kv = 0;
            if (kv > 65535)
                kv = 65535;
            stim_time += $urandom_range(1000, 50_000);
            send_item(ACT_POLL, stim_time, POT_W'(kv));
        end
    endtask

    // Random register settings: reset values first, then plausible settings,
    // one with no sender gaps and one with a wrapping timestamp, and a last one
    // with every register fully random.
    task automatic test_random_tracking;
        int target;
        int unsigned pick;
        for (int ph = 0; ph < 6; ph++) begin
            drain_results();
            if (ph == 0) begin
                set_reg(REG_REFRACTORY, 32'(RST_REFRACTORY));
                set_reg(REG_GAP,        32'(RST_GAP));
                set_reg(REG_TPERIODS,   32'(RST_TPERIODS));
                set_reg(REG_TMIN,       32'(RST_TMIN));
                set_reg(REG_TMAX,       32'(RST_TMAX));
                set_reg(REG_EPS,        32'(RST_EPS));
                set_reg(REG_UNITY,      32'(RST_UNITY));
                set_reg(REG_RATE_MAX,   32'(RST_RATE_MAX));
            end else if (ph == 5) begin
                for (int i = 0; i < NUM_REGS; i++)
                    set_reg(REG_IDX_W'(i), $urandom & REG_MASK[i]);
            end else begin
                set_reg(REG_REFRACTORY, $urandom_range(0, 2000));
                set_reg(REG_GAP,        $urandom_range(2_500_000, REG_MASK[REG_GAP]));
                set_reg(REG_TPERIODS,   $urandom_range(0, 31));
                set_reg(REG_TMIN,       $urandom_range(0, 1500));
                set_reg(REG_TMAX,       $urandom_range(0, 12_000));
                set_reg(REG_EPS,        ($urandom_range(0, 3) == 0) ? $urandom & REG_MASK[REG_EPS]
                                                                   : $urandom_range(0, 4000));
                set_reg(REG_UNITY,      $urandom_range(1, REG_MASK[REG_UNITY]));
                set_reg(REG_RATE_MAX,   $urandom & REG_MASK[REG_RATE_MAX]);
            end
            // fourth setting starts about a second before the timestamp wraps
            stim_time = (ph == 3) ? 40'hFF_FFF0_0000 : {8'($urandom), 32'($urandom)};
            steady_sender = (ph == 2);
            target = items_sent + ITEMS_PER_PH;
            while (items_sent < target) begin
                pick = $urandom_range(0, 19);
                if (pick < 2) begin
                    // noise: arbitrary kind, time and knob
                    repeat ($urandom_range(1, 4)) begin
                        stim_time = {8'($urandom), 32'($urandom)};
                        send_item(logic'($urandom_range(0, 1)), stim_time, POT_W'($urandom));
                    end
                end else if (pick == 2) begin
                    drain_results();
                end else begin
                    run_clock_segment(ph == 5);
                end
            end
        end
        steady_sender = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence
    initial begin
        reg_shadow[REG_REFRACTORY] = 32'(RST_REFRACTORY);
        reg_shadow[REG_GAP]        = 32'(RST_GAP);
        reg_shadow[REG_TPERIODS]   = 32'(RST_TPERIODS);
        reg_shadow[REG_TMIN]       = 32'(RST_TMIN);
        reg_shadow[REG_TMAX]       = 32'(RST_TMAX);
        reg_shadow[REG_EPS]        = 32'(RST_EPS);
        reg_shadow[REG_UNITY]      = 32'(RST_UNITY);
        reg_shadow[REG_RATE_MAX]   = 32'(RST_RATE_MAX);
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_register_defaults();
        test_directed_tracking();
        test_register_extremes();
        test_random_tracking();

        drain_results();
        repeat (200) @(posedge aclk);   // catch any stray result transfer

        $display("Covered %0d items: %0d accepted edges, %0d timeouts, %0d knob exits from hold.",
                 items_sent, edges_accepted, timeouts_seen, knob_exits);
        $display("Checked %0d results across %0d register writes, %0d mismatches.",
                 results_checked, reg_settings, error_count);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- ext_clock_tempo_tracker.f -----
sv/ectt_pkg.sv
sv/ectt_cfg.sv
sv/ectt_div.sv
sv/ext_clock_tempo_tracker.sv
test/tb_ext_clock_tempo_tracker.sv
